FILE: hdl/point_to_spherical_filter_unit_defines.svh
// Assertion macros shared by the point-to-spherical filter RTL.
`ifndef POINT_TO_SPHERICAL_FILTER_UNIT_DEFINES_SVH
`define POINT_TO_SPHERICAL_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptsf: same-cycle check failed");
`define PTSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptsf: next-cycle check failed");
`else
`define PTSF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/ptsf_pkg.sv
// Types, constants and the arctangent table of the point-to-spherical filter.
`default_nettype none
package ptsf_pkg;

   localparam int unsigned COORD_W      = 20;
   localparam int unsigned CFG_W        = 20;
   localparam int unsigned STRENGTH_W   = 16;
   localparam int unsigned ANGLE_W      = 16;
   localparam int unsigned PROJ_W       = 21;
   localparam int unsigned CSR_INDEX_W  = 4;
   localparam int unsigned SQ_W         = 40;
   localparam int unsigned SQRT_W       = 60;
   localparam int unsigned ROOT_W       = 30;
   localparam int unsigned SQRT_STEPS   = 30;
   localparam int unsigned CORDIC_STEPS = 30;
   localparam int unsigned CORDIC_W     = 34;
   localparam int unsigned NUM_W        = 51;
   localparam int unsigned DVS_W        = 31;
   localparam int unsigned QUO_W        = 30;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIZ    = 4'd1;

   localparam logic [CFG_W-1:0] CUTOFF_RESET = 20'd5120;
   localparam logic [CFG_W-1:0] VIZ_RESET    = 20'd5120;

   // Angle accumulator is in units of pi/2^31.
   localparam logic signed [CORDIC_W-1:0] ANGLE_PI   = 34'sh0_8000_0000;
   localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 34'sd32768;
   localparam logic signed [CORDIC_W-1:0] POLAR_MAX  = 34'sd32768;

   typedef struct packed {
      logic [SQRT_W-1:0] v;
      logic [SQRT_W-1:0] res;
   } sqrt_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] a;
      logic signed [CORDIC_W-1:0] b;
      logic signed [CORDIC_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
   } div_type;

   // Fields that travel beside the square-root chain.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      live;
      logic [SQ_W-1:0]           px;
      logic [SQ_W-1:0]           py;
      logic [SQ_W-1:0]           pz;
   } side1_type;

   // Fields that travel beside the angle and divider chains.
   typedef struct packed {
      logic             zero;
      logic             axis;
      logic [CFG_W-1:0] range;
      logic [CFG_W-1:0] margin;
      logic             sx;
      logic             sy;
      logic             sz;
   } side2_type;

   // Arctangent of 2^-step in units of pi/2^31.
   function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int step);
      logic signed [CORDIC_W-1:0] ang;
      case (step)
         0:  ang = 34'sd536870912;
         1:  ang = 34'sd316933406;
         2:  ang = 34'sd167458907;
         3:  ang = 34'sd85004756;
         4:  ang = 34'sd42667331;
         5:  ang = 34'sd21354465;
         6:  ang = 34'sd10679838;
         7:  ang = 34'sd5340245;
         8:  ang = 34'sd2670163;
         9:  ang = 34'sd1335087;
         10: ang = 34'sd667544;
         11: ang = 34'sd333772;
         12: ang = 34'sd166886;
         13: ang = 34'sd83443;
         14: ang = 34'sd41721;
         15: ang = 34'sd20860;
         16: ang = 34'sd10430;
         17: ang = 34'sd5215;
         18: ang = 34'sd2607;
         19: ang = 34'sd1303;
         20: ang = 34'sd651;
         21: ang = 34'sd325;
         22: ang = 34'sd162;
         23: ang = 34'sd81;
         24: ang = 34'sd40;
         25: ang = 34'sd20;
         26: ang = 34'sd10;
         27: ang = 34'sd5;
         28: ang = 34'sd2;
         29: ang = 34'sd1;
         default: ang = '0;
      endcase
      return ang;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/ptsf_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`default_nettype none
module ptsf_sqrt_cell #(
   parameter int unsigned BIT_POS = 0
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire ptsf_pkg::sqrt_type cell_in,
   output ptsf_pkg::sqrt_type      cell_out
);
   import ptsf_pkg::*;

   localparam logic [SQRT_W-1:0] BitVal = SQRT_W'(1) << BIT_POS;

   sqrt_type        out_ff;
   sqrt_type        out_in;
   logic [SQRT_W:0] trial;

   // Take the trial bit when the remainder covers it.
   always_comb begin
      trial = {1'b0, cell_in.res} + {1'b0, BitVal};
      if ({1'b0, cell_in.v} >= trial) begin
         out_in.v   = cell_in.v - trial[SQRT_W-1:0];
         out_in.res = (cell_in.res >> 1) + BitVal;
      end else begin
         out_in.v   = cell_in.v;
         out_in.res = cell_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

FILE: hdl/ptsf_cordic_cell.sv
// One vectoring rotation of the pipelined arctangent.
`default_nettype none
module ptsf_cordic_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire ptsf_pkg::cordic_type cell_in,
   output ptsf_pkg::cordic_type      cell_out
);
   import ptsf_pkg::*;

   localparam logic signed [CORDIC_W-1:0] Atan = cordic_atan(int'(STEP));

   cordic_type                 out_ff;
   cordic_type                 out_in;
   logic signed [CORDIC_W-1:0] a;
   logic signed [CORDIC_W-1:0] b;
   logic signed [CORDIC_W-1:0] sa;
   logic signed [CORDIC_W-1:0] sb;

   // Rotate toward the x axis by the direction of b.
   always_comb begin
      a  = cell_in.a;
      b  = cell_in.b;
      sa = a >>> STEP;
      sb = b >>> STEP;
      if (!b[CORDIC_W-1]) begin
         out_in.a = a + sb;
         out_in.b = b - sa;
         out_in.z = cell_in.z + Atan;
      end else begin
         out_in.a = a - sb;
         out_in.b = b + sa;
         out_in.z = cell_in.z - Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

FILE: hdl/ptsf_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module ptsf_div_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire ptsf_pkg::div_type cell_in,
   output ptsf_pkg::div_type      cell_out
);
   import ptsf_pkg::*;

   localparam int unsigned WIDE_W = DVS_W + QUO_W + 1;

   div_type           out_ff;
   div_type           out_in;
   logic [WIDE_W-1:0] shifted;

   // Subtract the shifted divisor when it fits.
   always_comb begin
      shifted = WIDE_W'(cell_in.dvs) << SHIFT;
      out_in  = cell_in;
      if (WIDE_W'(cell_in.rem) >= shifted) begin
         out_in.rem = cell_in.rem - shifted[NUM_W-1:0];
         out_in.quo = cell_in.quo | (QUO_W'(1) << SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

FILE: hdl/point_to_spherical_filter_unit.sv
// Top level of the lidar point filter with Cartesian to spherical conversion.
//
// Takes one point per cycle when not stalled and gives one result per point
// that has nonzero intensity and a range below the cutoff; other points leave
// no result. The design is a fixed pipeline: two stages of squaring, chains
// of 30 square-root cells, then chains of 30 arctangent cells and 30 divider
// cells side by side, and an output register. All stages move together, so
// the only stall is a result held in the output register while rsp_ready is
// low. Configuration writes are always accepted; write them only while no
// request is in flight.
`default_nettype none
`include "point_to_spherical_filter_unit_defines.svh"
module point_to_spherical_filter_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [ptsf_pkg::COORD_W-1:0]   req_x_pos,
   input  wire logic signed [ptsf_pkg::COORD_W-1:0]   req_y_pos,
   input  wire logic signed [ptsf_pkg::COORD_W-1:0]   req_z_pos,
   input  wire logic [ptsf_pkg::STRENGTH_W-1:0]       req_strength,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ptsf_pkg::ANGLE_W-1:0]        rsp_azimuth,
   output logic [ptsf_pkg::ANGLE_W-1:0]               rsp_polar_angle,
   output logic [ptsf_pkg::CFG_W-1:0]                 rsp_range_out,
   output logic [ptsf_pkg::CFG_W-1:0]                 rsp_margin,
   output logic signed [ptsf_pkg::PROJ_W-1:0]         rsp_proj_x,
   output logic signed [ptsf_pkg::PROJ_W-1:0]         rsp_proj_y,
   output logic signed [ptsf_pkg::PROJ_W-1:0]         rsp_proj_z,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ptsf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ptsf_pkg::CFG_W-1:0]            csr_data
);
   import ptsf_pkg::*;

   localparam int unsigned SIDE1_DEPTH = SQRT_STEPS + 2;
   localparam int unsigned SIDE2_DEPTH = CORDIC_STEPS;

   logic             advance;
   logic [CFG_W-1:0] cutoff_ff;
   logic [CFG_W-1:0] viz_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
         viz_ff    <= VIZ_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CUTOFF: cutoff_ff <= csr_data;
            CSR_VIZ:    viz_ff    <= csr_data;
            default:    ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // The whole pipeline moves unless a result waits in the output register.
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1: magnitudes, squares and projection numerators.
   logic [COORD_W-1:0] ax_mag, ay_mag, az_mag;
   logic [SQ_W-1:0]    ax2_in, ay2_in, az2_in, ax2_ff, ay2_ff, az2_ff;
   side1_type          side1_in;
   side1_type          side1_ff [SIDE1_DEPTH];
   logic               v1_ff [SIDE1_DEPTH];

   always_comb begin
      ax_mag = req_x_pos[COORD_W-1] ? COORD_W'(-req_x_pos) : COORD_W'(req_x_pos);
      ay_mag = req_y_pos[COORD_W-1] ? COORD_W'(-req_y_pos) : COORD_W'(req_y_pos);
      az_mag = req_z_pos[COORD_W-1] ? COORD_W'(-req_z_pos) : COORD_W'(req_z_pos);
      ax2_in = SQ_W'(ax_mag) * SQ_W'(ax_mag);
      ay2_in = SQ_W'(ay_mag) * SQ_W'(ay_mag);
      az2_in = SQ_W'(az_mag) * SQ_W'(az_mag);
      side1_in.x    = req_x_pos;
      side1_in.y    = req_y_pos;
      side1_in.z    = req_z_pos;
      side1_in.live = (req_strength != '0);
      side1_in.px   = SQ_W'(viz_ff) * SQ_W'(ax_mag);
      side1_in.py   = SQ_W'(viz_ff) * SQ_W'(ay_mag);
      side1_in.pz   = SQ_W'(viz_ff) * SQ_W'(az_mag);
   end

   // Stage 2: sums of squares.
   logic [SQ_W-1:0] hsq_in, ssq_in, hsq_ff, ssq_ff;

   always_comb begin
      hsq_in = ax2_ff + ay2_ff;
      ssq_in = hsq_in + az2_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax2_ff      <= ax2_in;
         ay2_ff      <= ay2_in;
         az2_ff      <= az2_in;
         hsq_ff      <= hsq_in;
         ssq_ff      <= ssq_in;
         side1_ff[0] <= side1_in;
         for (int i = 1; i < SIDE1_DEPTH; i++) begin
            side1_ff[i] <= side1_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE1_DEPTH; i++) begin
            v1_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff[0] <= req_valid;
         for (int i = 1; i < SIDE1_DEPTH; i++) begin
            v1_ff[i] <= v1_ff[i-1];
         end
      end
   end

   // Square-root chains: horizontal length and full length, both scaled by 1024.
   sqrt_type sqrt_h [SQRT_STEPS+1];
   sqrt_type sqrt_s [SQRT_STEPS+1];

   assign sqrt_h[0] = '{v: {hsq_ff, 20'b0}, res: '0};
   assign sqrt_s[0] = '{v: {ssq_ff, 20'b0}, res: '0};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      ptsf_sqrt_cell #(.BIT_POS(SQRT_W - 2 - 2 * k)) u_sqrt_h (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (sqrt_h[k]),
         .cell_out (sqrt_h[k+1])
      );
      ptsf_sqrt_cell #(.BIT_POS(SQRT_W - 2 - 2 * k)) u_sqrt_s (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (sqrt_s[k]),
         .cell_out (sqrt_s[k+1])
      );
   end

   // Filter decision and setup of the angle and divider chains.
   side1_type         s1;
   logic [ROOT_W-1:0] h_root, len_root;
   logic [CFG_W-1:0]  range_val;
   logic              keep;
   side2_type         side2_in;
   side2_type         side2_ff [SIDE2_DEPTH];
   logic              v2_ff [SIDE2_DEPTH];
   cordic_type        cor_az [CORDIC_STEPS+1];
   cordic_type        cor_po [CORDIC_STEPS+1];
   div_type           div_x [CORDIC_STEPS+1];
   div_type           div_y [CORDIC_STEPS+1];
   div_type           div_z [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] az_a, az_b, po_a, po_b;

   always_comb begin
      s1        = side1_ff[SIDE1_DEPTH-1];
      h_root    = sqrt_h[SQRT_STEPS].res[ROOT_W-1:0];
      len_root  = sqrt_s[SQRT_STEPS].res[ROOT_W-1:0];
      range_val = len_root[ROOT_W-1:ROOT_W-CFG_W];
      keep      = s1.live && (range_val < cutoff_ff);

      side2_in.zero   = (range_val == '0);
      side2_in.axis   = (s1.x == '0) && (s1.y == '0);
      side2_in.range  = range_val;
      side2_in.margin = cutoff_ff - range_val;
      side2_in.sx     = s1.x[COORD_W-1];
      side2_in.sy     = s1.y[COORD_W-1];
      side2_in.sz     = s1.z[COORD_W-1];

      // Fold a left-half vector into the right half by a turn of pi.
      az_a = {{4{s1.x[COORD_W-1]}}, s1.x, 10'b0};
      az_b = {{4{s1.y[COORD_W-1]}}, s1.y, 10'b0};
      if (az_a[CORDIC_W-1]) begin
         cor_az[0].a = -az_a;
         cor_az[0].b = -az_b;
         cor_az[0].z = az_b[CORDIC_W-1] ? -ANGLE_PI : ANGLE_PI;
      end else begin
         cor_az[0].a = az_a;
         cor_az[0].b = az_b;
         cor_az[0].z = '0;
      end

      po_a = {{4{s1.z[COORD_W-1]}}, s1.z, 10'b0};
      po_b = {4'b0, h_root};
      if (po_a[CORDIC_W-1]) begin
         cor_po[0].a = -po_a;
         cor_po[0].b = -po_b;
         cor_po[0].z = ANGLE_PI;
      end else begin
         cor_po[0].a = po_a;
         cor_po[0].b = po_b;
         cor_po[0].z = '0;
      end

      // Rounded quotient: (2*viz*|c|*1024 + len) / (2*len).
      div_x[0].rem = {s1.px, 11'b0} + NUM_W'(len_root);
      div_y[0].rem = {s1.py, 11'b0} + NUM_W'(len_root);
      div_z[0].rem = {s1.pz, 11'b0} + NUM_W'(len_root);
      div_x[0].dvs = {len_root, 1'b0};
      div_y[0].dvs = {len_root, 1'b0};
      div_z[0].dvs = {len_root, 1'b0};
      div_x[0].quo = '0;
      div_y[0].quo = '0;
      div_z[0].quo = '0;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_chain
      ptsf_cordic_cell #(.STEP(k)) u_cor_az (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (cor_az[k]),
         .cell_out (cor_az[k+1])
      );
      ptsf_cordic_cell #(.STEP(k)) u_cor_po (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (cor_po[k]),
         .cell_out (cor_po[k+1])
      );
      ptsf_div_cell #(.SHIFT(QUO_W - 1 - k)) u_div_x (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (div_x[k]),
         .cell_out (div_x[k+1])
      );
      ptsf_div_cell #(.SHIFT(QUO_W - 1 - k)) u_div_y (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (div_y[k]),
         .cell_out (div_y[k+1])
      );
      ptsf_div_cell #(.SHIFT(QUO_W - 1 - k)) u_div_z (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (div_z[k]),
         .cell_out (div_z[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side2_ff[0] <= side2_in;
         for (int i = 1; i < SIDE2_DEPTH; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   // Dropped points become bubbles here.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE2_DEPTH; i++) begin
            v2_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v2_ff[0] <= v1_ff[SIDE1_DEPTH-1] && keep;
         for (int i = 1; i < SIDE2_DEPTH; i++) begin
            v2_ff[i] <= v2_ff[i-1];
         end
      end
   end

   // Output stage: rounding, clamping, signs and the zero-range case.
   side2_type                  s2;
   logic signed [CORDIC_W-1:0] az_rnd, po_rnd;
   logic [PROJ_W-1:0]          qx, qy, qz;
   logic signed [ANGLE_W-1:0]  azimuth_in, azimuth_ff;
   logic [ANGLE_W-1:0]         polar_in, polar_ff;
   logic signed [PROJ_W-1:0]   proj_x_in, proj_y_in, proj_z_in;
   logic signed [PROJ_W-1:0]   proj_x_ff, proj_y_ff, proj_z_ff;
   logic [CFG_W-1:0]           range_ff, margin_ff;

   always_comb begin
      s2     = side2_ff[SIDE2_DEPTH-1];
      az_rnd = (cor_az[CORDIC_STEPS].z + ROUND_HALF) >>> 16;
      po_rnd = (cor_po[CORDIC_STEPS].z + ROUND_HALF) >>> 16;
      qx     = div_x[CORDIC_STEPS].quo[PROJ_W-1:0];
      qy     = div_y[CORDIC_STEPS].quo[PROJ_W-1:0];
      qz     = div_z[CORDIC_STEPS].quo[PROJ_W-1:0];

      azimuth_in = (s2.zero || s2.axis) ? '0 : az_rnd[ANGLE_W-1:0];

      if (s2.zero || po_rnd[CORDIC_W-1]) begin
         polar_in = '0;
      end else if (po_rnd > POLAR_MAX) begin
         polar_in = POLAR_MAX[ANGLE_W-1:0];
      end else begin
         polar_in = po_rnd[ANGLE_W-1:0];
      end

      if (s2.zero) begin
         proj_x_in = '0;
         proj_y_in = '0;
         proj_z_in = {1'b0, viz_ff};
      end else begin
         proj_x_in = s2.sx ? -qx : qx;
         proj_y_in = s2.sy ? -qy : qy;
         proj_z_in = s2.sz ? -qz : qz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v2_ff[SIDE2_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         azimuth_ff <= azimuth_in;
         polar_ff   <= polar_in;
         range_ff   <= s2.range;
         margin_ff  <= s2.margin;
         proj_x_ff  <= proj_x_in;
         proj_y_ff  <= proj_y_in;
         proj_z_ff  <= proj_z_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_azimuth     = azimuth_ff;
   assign rsp_polar_angle = polar_ff;
   assign rsp_range_out   = range_ff;
   assign rsp_margin      = margin_ff;
   assign rsp_proj_x      = proj_x_ff;
   assign rsp_proj_y      = proj_y_ff;
   assign rsp_proj_z      = proj_z_ff;

   // A delivered point always lies strictly inside the cutoff.
   `PTSF_ASSERT_IMP(a_margin_nonzero, clock, reset, rsp_valid, rsp_margin != '0)
   // The polar angle is clamped to the range zero through pi.
   `PTSF_ASSERT_IMP(a_polar_bound, clock, reset, rsp_valid, rsp_polar_angle <= 16'h8000)
   // A point at the origin reports both angles as zero.
   `PTSF_ASSERT_IMP(a_origin_angles, clock, reset, rsp_valid && rsp_range_out == '0, rsp_azimuth == '0 && rsp_polar_angle == '0)
   // A stall freezes the end of the pipeline.
   `PTSF_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(v2_ff[SIDE2_DEPTH-1]))
endmodule
`default_nettype wire

FILE: tb/sv/point_to_spherical_filter_unit_tb.sv
// Self-checking testbench for the point-to-spherical filter unit.
`timescale 1ns / 1ps
module point_to_spherical_filter_unit_tb;
   import ptsf_pkg::*;

   localparam int LATENCY     = 63;
   localparam int CYCLE_LIMIT = 400000;

   // A register index that the block does not decode.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 4'd7;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] azimuth;
      logic [ANGLE_W-1:0]        polar_angle;
      logic [CFG_W-1:0]          range_out;
      logic [CFG_W-1:0]          margin;
      logic signed [PROJ_W-1:0]  proj_x;
      logic signed [PROJ_W-1:0]  proj_y;
      logic signed [PROJ_W-1:0]  proj_z;
   } sphere_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_x_pos = '0, req_y_pos = '0, req_z_pos = '0;
   logic [STRENGTH_W-1:0] req_strength = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_azimuth;
   logic [ANGLE_W-1:0] rsp_polar_angle;
   logic [CFG_W-1:0] rsp_range_out, rsp_margin;
   logic signed [PROJ_W-1:0] rsp_proj_x, rsp_proj_y, rsp_proj_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   // Predictor copy of the two registers.
   logic [CFG_W-1:0] cutoff_shadow = CUTOFF_RESET;
   logic [CFG_W-1:0] viz_shadow = VIZ_RESET;

   sphere_point_type expected_points[$];
   int  errors = 0;
   int  cycles = 0;
   int  points_sent = 0, points_kept = 0, points_checked = 0;
   bit  rsp_calm = 1'b0;
   bit  req_calm = 1'b0;

   point_to_spherical_filter_unit u_dut (.*);

   always #2 clock = ~clock;

   // Floor square root, bit by bit.
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint cordic_angle_step(input int i);
      longint steps[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40,
         20, 10, 5, 2, 1};
      return steps[i];
   endfunction

   // Vectoring CORDIC arctangent of b/a, rounded to pi/32768 units.
   function automatic longint vector_angle(input longint a, input longint b);
      longint acc, t;
      acc = 0;
      if (a < 0) begin
         acc = (b >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         a = -a;
         b = -b;
      end
      for (int i = 0; i < 30; i++) begin
         if (b >= 0) begin
            t = a + (b >>> i);
            b = b - (a >>> i);
            acc = acc + cordic_angle_step(i);
         end else begin
            t = a - (b >>> i);
            b = b + (a >>> i);
            acc = acc - cordic_angle_step(i);
         end
         a = t;
      end
      return (acc + 32768) >>> 16;
   endfunction

   // Scale one coordinate onto the projection sphere, ties away from zero.
   function automatic logic signed [PROJ_W-1:0] sphere_coord(input longint c,
                                                           input longint unsigned len);
      longint unsigned mag, q;
      mag = (c < 0) ? -c : c;
      q = (longint'(viz_shadow) * mag * 2048 + len) / (2 * len);
      return (c < 0) ? -q[PROJ_W-1:0] : q[PROJ_W-1:0];
   endfunction

   // Work out the result of one point; returns 0 when the point is dropped.
   function automatic bit predict_sphere(input logic signed [COORD_W-1:0] xp,
         input logic signed [COORD_W-1:0] yp, input logic signed [COORD_W-1:0] zp,
         input logic [STRENGTH_W-1:0] str, output sphere_point_type res);
      longint x, y, z, azim, polar;
      longint unsigned hsq, ssq, range, len;
      x = xp; y = yp; z = zp;
      hsq = x * x + y * y;
      ssq = hsq + z * z;
      range = floor_sqrt(ssq);
      res = '0;
      if (str == 0 || range >= cutoff_shadow) return 0;
      res.range_out = CFG_W'(range);
      res.margin = CFG_W'(cutoff_shadow - range);
      if (ssq == 0) begin
         res.proj_z = PROJ_W'(viz_shadow);
         return 1;
      end
      azim = (x != 0 || y != 0) ? vector_angle(x * 1024, y * 1024) : 0;
      polar = vector_angle(z * 1024, floor_sqrt(hsq << 20));
      if (polar < 0) polar = 0;
      if (polar > 32768) polar = 32768;
      len = floor_sqrt(ssq << 20);
      res.azimuth = ANGLE_W'(azim);
      res.polar_angle = ANGLE_W'(polar);
      res.proj_x = sphere_coord(x, len);
      res.proj_y = sphere_coord(y, len);
      res.proj_z = sphere_coord(z, len);
      return 1;
   endfunction

   // Cycle counter with a hard stop.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time,
                  expected_points.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side backpressure.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= rsp_calm || ($urandom_range(99) >= 16);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      sphere_point_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_azimuth, rsp_polar_angle, rsp_range_out, rsp_margin,
                 rsp_proj_x, rsp_proj_y, rsp_proj_z};
         if (expected_points.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (got !== want) begin
               errors++;
               if (got.azimuth !== want.azimuth)
                  $display("%0t azimuth: expected %0d actual %0d", $time,
                           want.azimuth, got.azimuth);
               if (got.polar_angle !== want.polar_angle)
                  $display("%0t polar_angle: expected %0d actual %0d", $time,
                           want.polar_angle, got.polar_angle);
               if (got.range_out !== want.range_out)
                  $display("%0t range_out: expected %0d actual %0d", $time,
                           want.range_out, got.range_out);
               if (got.margin !== want.margin)
                  $display("%0t margin: expected %0d actual %0d", $time,
                           want.margin, got.margin);
               if (got.proj_x !== want.proj_x)
                  $display("%0t proj_x: expected %0d actual %0d", $time,
                           want.proj_x, got.proj_x);
               if (got.proj_y !== want.proj_y)
                  $display("%0t proj_y: expected %0d actual %0d", $time,
                           want.proj_y, got.proj_y);
               if (got.proj_z !== want.proj_z)
                  $display("%0t proj_z: expected %0d actual %0d", $time,
                           want.proj_z, got.proj_z);
            end
         end
      end
   end

   // Send one point request, with a random idle gap first. Valid stays high
   // on return so that requests can follow back to back.
   task automatic send_point(input logic signed [COORD_W-1:0] xp,
         input logic signed [COORD_W-1:0] yp, input logic signed [COORD_W-1:0] zp,
         input logic [STRENGTH_W-1:0] str);
      sphere_point_type res;
      while (!req_calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_pos <= xp;
      req_y_pos <= yp;
      req_z_pos <= zp;
      req_strength <= str;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_sphere(xp, yp, zp, str, res)) begin
         expected_points.insert(expected_points.size(), res);
         points_kept++;
      end
      points_sent++;
      @(negedge clock);
   endtask

   // Stop sending, wait for all results, then for the pipeline to drain.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write; the pipeline must already be drained.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CUTOFF) cutoff_shadow = value;
      else if (idx == CSR_VIZ) viz_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
      int v;
      v = $urandom_range(2 * span) - span;
      return COORD_W'(v);
   endfunction

   // Extremes of the fields and the named special cases at reset settings and at register extremes.
   task automatic test_directed();
      send_point(0, 0, 0, 16'h0400);              // zero range
      send_point(0, 0, 0, 16'h0000);              // dropped on intensity
      send_point(-1000, 0, 0, 16'hFFFF);          // azimuth at pi
      send_point(1000, 0, 0, 1);
      send_point(0, 1000, 0, 1);
      send_point(0, -1000, 0, 1);
      send_point(0, 0, 2000, 5);                  // on the z axis
      send_point(0, 0, -2000, 5);
      send_point(3000, -4000, 0, 7);
      send_point(5119, 0, 0, 9);                  // just inside the cutoff
      send_point(5120, 0, 0, 9);                  // at the cutoff
      send_point(-524288, -524288, -524288, 1);   // coordinate extremes
      send_point(524287, 524287, 524287, 1);
      drain_pipeline();
      write_register(CSR_CUTOFF, 20'hFFFFF);
      write_register(CSR_VIZ, 20'hFFFFF);
      send_point(-524288, 0, 0, 3);
      send_point(524287, -524288, 0, 3);
      send_point(0, 0, -524288, 3);
      send_point(300000, 300000, 300000, 3);
      send_point(-1, -1, 1, 3);
      drain_pipeline();
      write_register(CSR_SPARE, 20'h00001);       // unused index is ignored
      send_point(0, 0, 1, 3);
      drain_pipeline();
      write_register(CSR_CUTOFF, 20'd0);         // everything dropped
      write_register(CSR_VIZ, 20'd0);
      send_point(0, 0, 0, 1);
      send_point(10, 20, 30, 1);
      drain_pipeline();
   endtask

   // Random points under one register setting.
   task automatic test_random_phase(input logic [CFG_W-1:0] cutoff,
         input logic [CFG_W-1:0] viz, input int count, input int span);
      logic [STRENGTH_W-1:0] str;
      write_register(CSR_CUTOFF, cutoff);
      write_register(CSR_VIZ, viz);
      for (int n = 0; n < count; n++) begin
         req_calm = (n >= count / 3 && n < count / 2);
         rsp_calm = req_calm;
         str = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
         if ($urandom_range(9) == 0)
            send_point(rand_coord(4), rand_coord(4), rand_coord(4), str);
         else if ($urandom_range(4) == 0)
            send_point(rand_coord(524287), rand_coord(524287), 20'($urandom), str);
         else
            send_point(rand_coord(span), rand_coord(span), rand_coord(span), str);
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      drain_pipeline();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(CUTOFF_RESET, VIZ_RESET, 400, 4000);
      test_random_phase(20'hFFFFF, 20'hFFFFF, 400, 600000);
      test_random_phase(20'd1, 20'd1000, 150, 3);
      test_random_phase(20'd300000, 20'd0, 300, 250000);
      test_random_phase(20'd70000, 20'd77777, 400, 60000);
      $display("Sent %0d points, %0d passed the filter, %0d results checked,",
               points_sent, points_kept, points_checked);
      $display("across six register settings including both extremes.");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
